// ===== rtl/core/mib_pkg.sv =====
// Shared types, constants and subkey functions for the mini IDEA block cipher.
package mib_pkg;

    localparam int NUM_ROUNDS     = 4;
    localparam int KEYS_PER_ROUND = 6;
    localparam int NUM_SUBKEYS    = 28;
    localparam int KEY_W          = 32;
    localparam int BLOCK_W        = 16;
    localparam int ROT_AMOUNT     = 6;

    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    localparam logic [3:0] MUL_INV [16] = '{
        4'd0, 4'd1, 4'd9, 4'd6, 4'd13, 4'd7, 4'd3, 4'd5,
        4'd15, 4'd2, 4'd12, 4'd14, 4'd10, 4'd4, 4'd11, 4'd8
    };

    typedef logic [3:0] nibble_t;
    typedef logic [NUM_SUBKEYS-1:0][3:0] subkeys_t;

    typedef struct packed {
        nibble_t k0;
        nibble_t k1;
        nibble_t k2;
        nibble_t k3;
        nibble_t k4;
        nibble_t k5;
    } round_key_t;

    typedef struct packed {
        nibble_t k0;
        nibble_t k1;
        nibble_t k2;
        nibble_t k3;
    } layer_key_t;

    typedef struct packed {
        logic                 valid;
        logic                 command;
        logic [BLOCK_W-1:0]   blk;
    } cell_tok_t;

    // Multiply modulo 17, zero standing for 16; uses 16 == -1 (mod 17).
    function automatic nibble_t mul17(nibble_t a, nibble_t b);
        logic [4:0] x;
        logic [4:0] y;
        logic [8:0] p;
        logic [3:0] lo;
        logic [4:0] hi;
        logic [5:0] d;
        x  = (a == 4'd0) ? 5'd16 : {1'b0, a};
        y  = (b == 4'd0) ? 5'd16 : {1'b0, b};
        p  = 9'(x * y);
        lo = p[3:0];
        hi = p[8:4];
        if ({1'b0, lo} >= hi) begin
            d = {2'b00, lo} - {1'b0, hi};
        end else begin
            d = {2'b00, lo} + 6'd17 - {1'b0, hi};
        end
        return (d == 6'd16) ? 4'd0 : d[3:0];
    endfunction

    function automatic nibble_t add16(nibble_t a, nibble_t b);
        return a + b;
    endfunction

    function automatic subkeys_t make_enc_keys(logic [KEY_W-1:0] key);
        logic [KEY_W-1:0] k;
        subkeys_t         sk;
        k  = key;
        sk = '0;
        for (int w = 0; w < 4; w++) begin
            for (int n = 0; n < 8; n++) begin
                if (w * 8 + n < NUM_SUBKEYS) begin
                    sk[w * 8 + n] = k[KEY_W - 1 - 4 * n -: 4];
                end
            end
            k = {k[KEY_W-ROT_AMOUNT-1:0], k[KEY_W-1:KEY_W-ROT_AMOUNT]};
        end
        return sk;
    endfunction

    function automatic subkeys_t make_dec_keys(subkeys_t ek);
        subkeys_t dk;
        int       src;
        dk = '0;
        for (int i = 0; i < 5; i++) begin
            src = (4 - i) * 6;
            dk[i * 6 + 0] = MUL_INV[ek[src + 0]];
            dk[i * 6 + 1] = 4'd0 - ek[src + 1];
            dk[i * 6 + 2] = 4'd0 - ek[src + 2];
            dk[i * 6 + 3] = MUL_INV[ek[src + 3]];
            if (i < 4) begin
                dk[i * 6 + 4] = ek[(3 - i) * 6 + 4];
                dk[i * 6 + 5] = ek[(3 - i) * 6 + 5];
            end
        end
        return dk;
    endfunction

endpackage

// ===== rtl/core/mib_round_cell.sv =====
// One cipher round cell: registered stage with its own valid and backpressure.
module mib_round_cell (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  mib_pkg::cell_tok_t     tok_in,
    output logic                   ready_out,
    output mib_pkg::cell_tok_t     tok_out,
    input  logic                   ready_in,
    input  mib_pkg::round_key_t    enc_key,
    input  mib_pkg::round_key_t    dec_key
);

    mib_pkg::round_key_t             key;
    mib_pkg::nibble_t                a, b, c, d, p, q, t;
    logic [mib_pkg::BLOCK_W-1:0]     blk_next;
    logic [mib_pkg::BLOCK_W-1:0]     blk_reg;
    logic                            command_reg;
    logic                            valid_reg;
    logic                            valid_next;
    logic                            load;

    assign ready_out = !valid_reg || ready_in;
    assign load      = ready_out && tok_in.valid;

    always_comb begin
        key = (tok_in.command == mib_pkg::CMD_DECRYPT) ? dec_key : enc_key;
        a   = mib_pkg::mul17(tok_in.blk[15:12], key.k0);
        b   = mib_pkg::add16(tok_in.blk[11:8], key.k1);
        c   = mib_pkg::add16(tok_in.blk[7:4], key.k2);
        d   = mib_pkg::mul17(tok_in.blk[3:0], key.k3);
        p   = mib_pkg::mul17(a ^ c, key.k4);
        q   = mib_pkg::mul17(mib_pkg::add16(b ^ d, p), key.k5);
        t   = mib_pkg::add16(p, q);
        blk_next   = {a ^ q, b ^ t, c ^ q, d ^ t};
        valid_next = ready_out ? tok_in.valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            blk_reg     <= blk_next;
            command_reg <= tok_in.command;
        end
    end

    assign tok_out = '{valid: valid_reg, command: command_reg, blk: blk_reg};

endmodule

// ===== rtl/core/mib_key_layer.sv =====
// Final key layer cell; its register is the result register.
module mib_key_layer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  mib_pkg::cell_tok_t            tok_in,
    output logic                          ready_out,
    output logic                          out_valid,
    output logic [mib_pkg::BLOCK_W-1:0]   out_block,
    input  logic                          ready_in,
    input  mib_pkg::layer_key_t           enc_key,
    input  mib_pkg::layer_key_t           dec_key
);

    mib_pkg::layer_key_t             key;
    logic [mib_pkg::BLOCK_W-1:0]     blk_next;
    logic [mib_pkg::BLOCK_W-1:0]     blk_reg;
    logic                            valid_reg;
    logic                            valid_next;

    assign ready_out = !valid_reg || ready_in;

    always_comb begin
        key = (tok_in.command == mib_pkg::CMD_DECRYPT) ? dec_key : enc_key;
        blk_next = {mib_pkg::mul17(tok_in.blk[15:12], key.k0),
                    mib_pkg::add16(tok_in.blk[11:8], key.k1),
                    mib_pkg::add16(tok_in.blk[7:4], key.k2),
                    mib_pkg::mul17(tok_in.blk[3:0], key.k3)};
        valid_next = ready_out ? tok_in.valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_out && tok_in.valid) begin
            blk_reg <= blk_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_block = blk_reg;

endmodule

// ===== rtl/core/mini_idea_block_cipher.sv =====
// Top level of the mini IDEA block cipher: key register and chain of round cells.
//
//   channel   direction  handshake              payload
//   cfg       in         cfg_valid / cfg_ready  cfg_data[31:0] (cipher_key)
//   s         in         s_valid / s_ready      s_command, s_block_in[15:0]
//   m         out        m_valid / m_ready      m_block_out[15:0]
//
// An input transfer passes through four round cells and the key layer before its earliest
// output transfer; m_valid rises once the block is registered in the key layer.
// One block per cycle is accepted while the chain is moving; each cell stalls only when
// it holds data and its neighbor is full. Subkeys follow the key register combinationally.
// Synchronous active-low reset clears all valid bits and the key; cfg_ready stays high.
module mini_idea_block_cipher (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mib_pkg::KEY_W-1:0]     cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_command,
    input  logic [mib_pkg::BLOCK_W-1:0]   s_block_in,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [mib_pkg::BLOCK_W-1:0]   m_block_out
);

    logic [mib_pkg::KEY_W-1:0]   key_reg;
    mib_pkg::subkeys_t           enc_keys;
    mib_pkg::subkeys_t           dec_keys;
    mib_pkg::cell_tok_t          tok [mib_pkg::NUM_ROUNDS+1];
    logic                        rdy [mib_pkg::NUM_ROUNDS+1];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg <= '0;
        end else if (cfg_valid) begin
            key_reg <= cfg_data;
        end
    end

    assign enc_keys = mib_pkg::make_enc_keys(key_reg);
    assign dec_keys = mib_pkg::make_dec_keys(enc_keys);

    assign tok[0]  = '{valid: s_valid, command: s_command, blk: s_block_in};
    assign s_ready = rdy[0];

    for (genvar r = 0; r < mib_pkg::NUM_ROUNDS; r++) begin : g_round
        localparam int B = r * mib_pkg::KEYS_PER_ROUND;
        mib_round_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .tok_in    (tok[r]),
            .ready_out (rdy[r]),
            .tok_out   (tok[r+1]),
            .ready_in  (rdy[r+1]),
            .enc_key   ({enc_keys[B], enc_keys[B+1], enc_keys[B+2],
                         enc_keys[B+3], enc_keys[B+4], enc_keys[B+5]}),
            .dec_key   ({dec_keys[B], dec_keys[B+1], dec_keys[B+2],
                         dec_keys[B+3], dec_keys[B+4], dec_keys[B+5]})
        );
    end

    localparam int LB = mib_pkg::NUM_ROUNDS * mib_pkg::KEYS_PER_ROUND;

    mib_key_layer u_layer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tok_in    (tok[mib_pkg::NUM_ROUNDS]),
        .ready_out (rdy[mib_pkg::NUM_ROUNDS]),
        .out_valid (m_valid),
        .out_block (m_block_out),
        .ready_in  (m_ready),
        .enc_key   ({enc_keys[LB], enc_keys[LB+1], enc_keys[LB+2], enc_keys[LB+3]}),
        .dec_key   ({dec_keys[LB], dec_keys[LB+1], dec_keys[LB+2], dec_keys[LB+3]})
    );

    a_full_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled while output side can move");

    a_cell_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        tok[0].valid && rdy[0] |=> tok[1].valid)
        else $error("transfer into first cell lost");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("chain not empty after reset");

endmodule
